@@ design/cpc_pkg.sv @@
// Package with shared constants, codes and controller/datapath interface types.
package cpc_pkg;

    localparam int MAX_ENTRIES_DEF = 8192;
    localparam int ENTRY_BITS_DEF  = 32;

    localparam int VALUE_W    = 32;
    localparam int OPCODE_W   = 2;
    localparam int LEVEL_W    = 3;
    localparam int COMBINED_W = 64;
    localparam int PAIR_W     = 27;
    localparam int SHIFT_W    = 6;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_SAT = 6'd32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NEXT   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic clear;
        logic append;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_status;

endpackage

@@ design/cpc_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module cpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ design/cpc_ctrl.sv @@
// Controller state machine that sequences requests, the pair scan and result handoff.
module cpc_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    input  logic [cpc_pkg::OPCODE_W-1:0]       i_opcode,
    output logic                               o_s_ready,
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    input  cpc_pkg::t_status                   i_status,
    output cpc_pkg::t_cmd                      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_ready  = 1'b0;
        o_m_valid  = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    case (cpc_pkg::t_opcode'(i_opcode))
                        cpc_pkg::OP_CLEAR:  o_cmd.clear = 1'b1;
                        cpc_pkg::OP_APPEND: o_cmd.append = 1'b1;
                        cpc_pkg::OP_NEXT:   n_state = S_SCAN;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.exhausted) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_m_valid = 1'b1;
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ design/cpc_dp.sv @@
// Datapath with the entry table, scan cursors, subset test and result registers.
module cpc_dp #(
    parameter int MAX_ENTRIES = cpc_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_BITS  = cpc_pkg::ENTRY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpc_pkg::t_cmd                       i_cmd,
    input  logic [cpc_pkg::VALUE_W-1:0]         i_value,
    input  logic                                i_cfg_we,
    input  logic [cpc_pkg::LEVEL_W-1:0]         i_cfg_level,
    output cpc_pkg::t_status                    o_status,
    output logic [cpc_pkg::COMBINED_W-1:0]      o_combined,
    output logic [cpc_pkg::PAIR_W-1:0]          o_pair_number,
    output logic                                o_done
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_row, n_row;
    logic [CW-1:0]                      r_col, n_col;
    logic                               r_pend_valid, n_pend_valid;
    logic [CW-1:0]                      r_pend_row, n_pend_row;
    logic [CW-1:0]                      r_pend_col, n_pend_col;
    logic [cpc_pkg::PAIR_W-1:0]         r_pairs, n_pairs;
    logic [cpc_pkg::LEVEL_W-1:0]        r_level;
    logic [cpc_pkg::COMBINED_W-1:0]     r_combined, n_combined;
    logic [cpc_pkg::PAIR_W-1:0]         r_pair_number, n_pair_number;
    logic                               r_done, n_done;

    logic                               we;
    logic [ENTRY_BITS-1:0]              rdata_a;
    logic [ENTRY_BITS-1:0]              rdata_b;
    logic [cpc_pkg::SHIFT_W-1:0]        shamt;
    logic [cpc_pkg::PAIR_W-1:0]         pairs_inc;

    cpc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_value[ENTRY_BITS-1:0]),
        .i_raddr_a (r_row[AW-1:0]),
        .i_raddr_b (r_col[AW-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign shamt = (r_level > cpc_pkg::LEVEL_MAX) ? cpc_pkg::SHIFT_SAT
                                                  : cpc_pkg::SHIFT_W'(1) << r_level;
    assign pairs_inc = r_pairs + cpc_pkg::PAIR_W'(1);

    assign o_status.hit       = r_pend_valid && ((rdata_a & ~rdata_b) == '0);
    assign o_status.exhausted = !r_pend_valid && (r_row >= r_count);

    always_comb begin
        n_count       = r_count;
        n_row         = r_row;
        n_col         = r_col;
        n_pend_valid  = r_pend_valid;
        n_pend_row    = r_pend_row;
        n_pend_col    = r_pend_col;
        n_pairs       = r_pairs;
        n_combined    = r_combined;
        n_pair_number = r_pair_number;
        n_done        = r_done;
        we            = 1'b0;
        if (i_cmd.clear) begin
            n_count      = '0;
            n_row        = '0;
            n_col        = '0;
            n_pairs      = '0;
            n_pend_valid = 1'b0;
        end
        if (i_cmd.append && (r_count < CW'(MAX_ENTRIES))) begin
            we      = 1'b1;
            n_count = r_count + CW'(1);
        end
        if (i_cmd.scan) begin
            if (o_status.hit) begin
                n_pairs       = pairs_inc;
                n_pair_number = pairs_inc;
                n_combined    = (cpc_pkg::COMBINED_W'(rdata_a) << shamt)
                                | cpc_pkg::COMBINED_W'(rdata_b);
                n_done        = 1'b0;
                n_row         = r_pend_row;
                n_col         = r_pend_col;
                n_pend_valid  = 1'b0;
            end else if (o_status.exhausted) begin
                n_combined    = '0;
                n_pair_number = r_pairs;
                n_done        = 1'b1;
            end else if (r_row >= r_count) begin
                n_pend_valid = 1'b0;
            end else if (r_col >= r_count) begin
                n_row        = r_row + CW'(1);
                n_col        = '0;
                n_pend_valid = 1'b0;
            end else begin
                n_pend_valid = 1'b1;
                n_pend_row   = r_row;
                n_pend_col   = r_col + CW'(1);
                n_col        = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_pend_valid <= 1'b0;
            r_pairs      <= '0;
            r_level      <= '0;
        end else begin
            r_count      <= n_count;
            r_row        <= n_row;
            r_col        <= n_col;
            r_pend_valid <= n_pend_valid;
            r_pairs      <= n_pairs;
            if (i_cfg_we) begin
                r_level <= i_cfg_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_row    <= n_pend_row;
        r_pend_col    <= n_pend_col;
        r_combined    <= n_combined;
        r_pair_number <= n_pair_number;
        r_done        <= n_done;
    end

    assign o_combined    = r_combined;
    assign o_pair_number = r_pair_number;
    assign o_done        = r_done;

endmodule

@@ design/comparable_pair_concatenator_core.sv @@
// Top level of the comparable pair concatenator: stream ports, controller and datapath.
// A clear or append request is carried out without leaving the idle state; one request is handled at a time.
// A next request tests one stored pair per cycle from a two-read-port table RAM, with a
// row-advance step after each finished row, a registered RAM read and a result capture.
// The result is held in an output register until taken, then the next request is accepted.
// Synchronous active-low reset clears the control state, cursors, counts and level;
// the table itself is not cleared and needs no clearing pass.
module comparable_pair_concatenator_core #(
    parameter int MAX_ENTRIES = cpc_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_BITS  = cpc_pkg::ENTRY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // entry_value
    input  logic [cpc_pkg::VALUE_W-1:0]         i_s_tdata,
    // opcode
    input  logic [cpc_pkg::OPCODE_W-1:0]        i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // combined_word, pair_number, zero padding
    output logic [cpc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // done_res
    output logic [cpc_pkg::OUT_USER_W-1:0]      o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpc_pkg::LEVEL_W-1:0]         i_cfg_data
);

    cpc_pkg::t_cmd                  cmd;
    cpc_pkg::t_status               status;
    logic [cpc_pkg::COMBINED_W-1:0] combined;
    logic [cpc_pkg::PAIR_W-1:0]     pair_number;
    logic                           done;

    assign o_cfg_ready = 1'b1;

    cpc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_opcode  (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    cpc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (i_s_tdata),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_level   (i_cfg_data),
        .o_status      (status),
        .o_combined    (combined),
        .o_pair_number (pair_number),
        .o_done        (done)
    );

    assign o_m_tdata = {{(cpc_pkg::OUT_DATA_W - cpc_pkg::COMBINED_W - cpc_pkg::PAIR_W){1'b0}},
                        pair_number, combined};
    assign o_m_tuser = done;

endmodule
